// ===== src/api_frame_deframer_top_assert.svh =====
// Assertion macros shared by the deframer RTL modules.
// Needs nothing else; each use names the clock and the active-low reset.
`ifndef API_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define API_FRAME_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define AFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is low
`define AFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer assertion failed (next cycle)");

`endif

// ===== src/afd_pkg.sv =====
// Types and constants of the API frame deframer.
// No dependencies; used by the interfaces, the parser and the top level.
package afd_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [16:0] t_count;

    localparam t_byte  DELIM_BYTE     = 8'h7E;
    localparam t_byte  ESC_BYTE       = 8'h7D;
    localparam t_byte  ESC_XOR        = 8'h20;
    localparam t_count FRAME_OVERHEAD = 17'd4;

    // One result from the parser for the accepted byte
    typedef struct packed {
        logic  valid;
        t_byte frame_byte;
        logic  first_of_frame;
        logic  last_of_frame;
    } t_result;

endpackage

// ===== src/afd_in_if.sv =====
// Input byte channel of the deframer: valid, ready and one raw byte.
// Depends on afd_pkg for the byte type.
interface afd_in_if;
    logic          valid;
    logic          ready;
    afd_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/afd_out_if.sv =====
// Output frame-byte channel of the deframer: valid, ready, byte and flags.
// Depends on afd_pkg for the byte type.
interface afd_out_if;
    logic           valid;
    logic           ready;
    afd_pkg::t_byte frame_byte;
    logic           first_of_frame;
    logic           last_of_frame;

    modport source (output valid, output frame_byte, output first_of_frame,
                    output last_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input first_of_frame,
                    input last_of_frame, output ready);
endinterface

// ===== src/afd_parser.sv =====
// Frame parser: delimiter hunt, unescaping, length capture and byte count.
// Depends on afd_pkg and the assertion macro header.
module afd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  afd_pkg::t_byte   i_rx_byte,
    input  logic             i_escaped_mode,
    output afd_pkg::t_result o_result
);
    import afd_pkg::*;

    logic   r_in_frame, n_in_frame;
    logic   r_escape_pending, n_escape_pending;
    t_count r_byte_count, n_byte_count;
    t_byte  r_length_high, n_length_high;
    t_count r_frame_total, n_frame_total;
    logic   r_size_known, n_size_known;

    t_byte   w_data;
    t_count  w_count_inc;
    logic    w_last;
    t_result w_res;

    // Decode one accepted byte against the running frame state
    always_comb begin
        n_in_frame       = r_in_frame;
        n_escape_pending = r_escape_pending;
        n_byte_count     = r_byte_count;
        n_length_high    = r_length_high;
        n_frame_total    = r_frame_total;
        n_size_known     = r_size_known;
        w_data           = r_escape_pending ? (i_rx_byte ^ ESC_XOR) : i_rx_byte;
        w_count_inc      = r_byte_count + 17'd1;
        w_last           = 1'b0;
        w_res            = '{valid: 1'b0, frame_byte: w_data,
                             first_of_frame: 1'b0, last_of_frame: 1'b0};

        if (i_accept) begin
            if (!r_in_frame) begin
                // Hunt for the start delimiter, drop everything else
                if (i_rx_byte == DELIM_BYTE) begin
                    n_in_frame       = 1'b1;
                    n_escape_pending = 1'b0;
                    n_byte_count     = 17'd1;
                    n_length_high    = '0;
                    n_frame_total    = '0;
                    n_size_known     = 1'b0;
                    w_res.valid          = 1'b1;
                    w_res.frame_byte     = DELIM_BYTE;
                    w_res.first_of_frame = 1'b1;
                end
            end else if (i_escaped_mode && i_rx_byte == DELIM_BYTE) begin
                // Ignore a raw delimiter inside an escaped frame
            end else if (!r_escape_pending && i_escaped_mode && i_rx_byte == ESC_BYTE) begin
                n_escape_pending = 1'b1;
            end else begin
                // Pass one unescaped frame byte on
                n_escape_pending = 1'b0;
                if (r_byte_count == 17'd1) begin
                    n_length_high = w_data;
                end
                if (r_byte_count == 17'd2) begin
                    n_frame_total = t_count'({r_length_high, w_data}) + FRAME_OVERHEAD;
                    n_size_known  = 1'b1;
                end
                n_byte_count = w_count_inc;
                w_last       = n_size_known && (w_count_inc == n_frame_total);
                w_res.valid         = 1'b1;
                w_res.last_of_frame = w_last;
                if (w_last) begin
                    n_in_frame       = 1'b0;
                    n_escape_pending = 1'b0;
                    n_byte_count     = '0;
                    n_length_high    = '0;
                    n_frame_total    = '0;
                    n_size_known     = 1'b0;
                end
            end
        end
    end

    assign o_result = w_res;

    // Hold the frame state, clear it at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame       <= 1'b0;
            r_escape_pending <= 1'b0;
            r_byte_count     <= '0;
            r_length_high    <= '0;
            r_frame_total    <= '0;
            r_size_known     <= 1'b0;
        end else begin
            r_in_frame       <= n_in_frame;
            r_escape_pending <= n_escape_pending;
            r_byte_count     <= n_byte_count;
            r_length_high    <= n_length_high;
            r_frame_total    <= n_frame_total;
            r_size_known     <= n_size_known;
        end
    end

`include "api_frame_deframer_top_assert.svh"
    `AFD_ASSERT_IMPL(a_count_tracks_frame, i_clk, i_rst_n, 1'b1, r_in_frame == (r_byte_count != '0))
    `AFD_ASSERT_IMPL(a_count_below_total, i_clk, i_rst_n, r_size_known, r_byte_count < r_frame_total)
    `AFD_ASSERT_IMPL(a_escape_in_frame, i_clk, i_rst_n, r_escape_pending, r_in_frame)

endmodule

// ===== src/api_frame_deframer_top.sv =====
// Top level of the API frame deframer: configuration register, parser and
// output register. Depends on afd_pkg, afd_in_if, afd_out_if, afd_parser.
//
// Usage:
//   i_in   : raw serial bytes, one per transfer (valid/ready).
//   o_out  : frame bytes with first/last flags, one per transfer.
//   cfg    : i_cfg_valid/i_cfg_data write escaped_mode; o_cfg_ready is always
//            high, write only while no frame byte is in flight.
// Bytes before a 0x7E delimiter are dropped. The delimiter comes out flagged
// first; the byte that completes length+4 unescaped bytes comes out flagged
// last. In escaped mode 0x7D is dropped and the next byte is XORed with 0x20.
// Latency: a result is registered and appears on o_out in the cycle after its input transfer.
// Throughput: one byte per cycle unless o_out stalls, set by the single output register, which
// is refilled in the cycle it is taken. Dropped bytes give no result.
// Stall: while a result waits with o_out.ready low, i_in.ready is low; the
// result and the frame state hold.
// Reset (i_rst_n low, synchronous): back to delimiter hunt, escaped mode off,
// output empty.
module api_frame_deframer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    afd_in_if.sink    i_in,
    afd_out_if.source o_out,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_data,
    output logic      o_cfg_ready
);
    import afd_pkg::*;

    logic    r_escaped_mode;
    logic    r_out_valid;
    t_byte   r_out_byte;
    logic    r_out_first;
    logic    r_out_last;
    logic    w_in_ready;
    logic    w_accept;
    t_result w_result;

    // Take a byte whenever the output register is free or being emptied
    assign w_in_ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && w_in_ready;
    assign i_in.ready  = w_in_ready;
    assign o_cfg_ready = 1'b1;

    // Hold the escape mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escaped_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_escaped_mode <= i_cfg_data;
        end
    end

    afd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_rx_byte      (i_in.rx_byte),
        .i_escaped_mode (r_escaped_mode),
        .o_result       (w_result)
    );

    // Advance the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_out_valid <= w_result.valid;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (w_in_ready && w_result.valid) begin
            r_out_byte  <= w_result.frame_byte;
            r_out_first <= w_result.first_of_frame;
            r_out_last  <= w_result.last_of_frame;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.frame_byte     = r_out_byte;
    assign o_out.first_of_frame = r_out_first;
    assign o_out.last_of_frame  = r_out_last;

`include "api_frame_deframer_top_assert.svh"
    `AFD_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, w_accept && w_result.valid, r_out_valid)
    `AFD_ASSERT_IMPL(a_first_is_delim, i_clk, i_rst_n, r_out_valid && r_out_first, r_out_byte == DELIM_BYTE)
    `AFD_ASSERT_IMPL(a_first_not_last, i_clk, i_rst_n, r_out_valid, !(r_out_first && r_out_last))

endmodule
